// ----- design/jps_pkg.sv -----
// Shared types and constants for the joint position smoother.
// Used by the smoother unit and the divider; depends on nothing.
package jps_pkg;

  localparam int NUM_POINTS = 26;
  localparam int MAX_WINDOW = 8;
  localparam int COORD_BITS = 16;
  localparam int NUM_COORDS = 3;

  localparam int PIDX_W   = 5;
  localparam int STATE_W  = 2;
  localparam int WEIGHT_W = 9;
  localparam int WIN_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam int PT_W   = $clog2(NUM_POINTS);
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = COORD_BITS + $clog2(MAX_WINDOW);

  localparam int HIST_W     = NUM_COORDS * COORD_BITS;
  localparam int HIST_DEPTH = NUM_POINTS * MAX_WINDOW;
  localparam int ADDR_W     = $clog2(HIST_DEPTH);

  localparam int ONE_Q8  = 256;
  localparam int HALF_Q8 = 128;
  localparam int FRAC_Q8 = 8;

  localparam logic [STATE_W-1:0] STATE_TRACKED = 2'd2;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_SMA  = 2'd1,
    MODE_WMA  = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WINDOW = 2'd1,
    CFG_WEIGHT = 2'd2
  } cfg_reg_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

endpackage

// ----- design/joint_position_smoother_unit.sv -----
// Joint position smoother: per-point sample history with pass, SMA and WMA modes.
// From input accept: pass-through goes WRITE then OUT; WMA goes READ, then MUL and ADD
// per coordinate; SMA goes READ then DIV (bit-serial divider, 19 steps), then OUT.
// One item in flight: a new input is accepted only in IDLE, after the result is taken.
// Reset clears mode/window/weight to 0/3/205 and all fill counts and ring slots;
// the history RAM is not cleared and no slot is read before it is written.
module joint_position_smoother_unit import jps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PIDX_W-1:0]    point_index_i,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic [COORD_BITS-1:0] pos_z_i,
  input  logic [STATE_W-1:0]   track_state_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIDX_W-1:0]    out_index_o,
  output logic [COORD_BITS-1:0] smooth_x_o,
  output logic [COORD_BITS-1:0] smooth_y_o,
  output logic [COORD_BITS-1:0] smooth_z_o,
  output logic [STATE_W-1:0]   out_state_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WEIGHT_W-1:0]  cfg_data_i
);

  localparam int PROD_W = COORD_BITS + 1 + WEIGHT_W + 1;
  localparam int T_W    = PROD_W + 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_WRITE = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_ADD   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } fsm_e;

  fsm_e state_q;

  logic [1:0]          mode_q;
  logic [WIN_W-1:0]    window_q;
  logic [WEIGHT_W-1:0] weight_q;

  logic [FILL_W-1:0] fill_q [NUM_POINTS];
  logic [SLOT_W-1:0] slot_q [NUM_POINTS];

  logic [SLOT_W-1:0] base_slot_q;
  logic [FILL_W-1:0] n_q;
  logic [FILL_W-1:0] k_q;
  logic              rd_pend_q;
  logic              wma_q;
  logic              div_go_q;
  logic [1:0]        c_q;

  logic [PIDX_W-1:0]  pidx_q;
  logic [STATE_W-1:0] tstate_q;
  logic [STATE_W-1:0] ostate_q;
  coord_t             cur_q  [NUM_COORDS];
  coord_t             prev_q [NUM_COORDS];
  coord_t             res_q  [NUM_COORDS];
  sum_t               acc_q  [NUM_COORDS];
  logic signed [PROD_W-1:0] prod_q;

  logic [PT_W-1:0]    pt;
  logic               in_range;
  logic [FILL_W-1:0]  fill_new;
  logic [FILL_W-1:0]  win;
  logic               go_sma;
  logic               go_wma;
  logic [FILL_W:0]    rd_tmp;
  logic [SLOT_W-1:0]  rd_slot;
  logic               last_rd;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [HIST_W-1:0]  ram_wdata;
  logic [HIST_W-1:0]  ram_rdata;

  logic               div_done;
  coord_t             quot [NUM_COORDS];

  logic [WEIGHT_W-1:0]        w_sat;
  logic signed [WEIGHT_W:0]   w_ext;
  logic signed [COORD_BITS:0] diff;
  logic signed [T_W-1:0]      wma_t;

  function automatic logic [ADDR_W-1:0] hist_addr(logic [PT_W-1:0] p, logic [SLOT_W-1:0] s);
    return ADDR_W'(p) * ADDR_W'(MAX_WINDOW) + ADDR_W'(s);
  endfunction

  // Point decode and smoothing decision
  assign pt       = pidx_q[PT_W-1:0];
  assign in_range = pidx_q < PIDX_W'(NUM_POINTS);
  assign fill_new = (fill_q[pt] < FILL_W'(MAX_WINDOW)) ? fill_q[pt] + FILL_W'(1) : fill_q[pt];

  always_comb begin
    if (window_q == '0) begin
      win = FILL_W'(1);
    end else if (FILL_W'(window_q) > FILL_W'(MAX_WINDOW)) begin
      win = FILL_W'(MAX_WINDOW);
    end else begin
      win = FILL_W'(window_q);
    end
  end

  assign go_sma = in_range && (mode_q == MODE_SMA) && (fill_new >= win);
  assign go_wma = in_range && (mode_q == MODE_WMA) && (fill_new >= FILL_W'(2));

  // k-th newest slot, counted back from the slot just written
  assign rd_tmp  = (FILL_W+1)'(base_slot_q) + (FILL_W+1)'(MAX_WINDOW) - (FILL_W+1)'(k_q);
  assign rd_slot = (rd_tmp >= (FILL_W+1)'(MAX_WINDOW)) ?
                   SLOT_W'(rd_tmp - (FILL_W+1)'(MAX_WINDOW)) : SLOT_W'(rd_tmp);
  assign last_rd = (state_q == ST_READ) && (k_q == n_q);

  assign ram_we    = (state_q == ST_WRITE) && in_range;
  assign ram_waddr = hist_addr(pt, slot_q[pt]);
  assign ram_wdata = {cur_q[2], cur_q[1], cur_q[0]};
  assign ram_raddr = hist_addr(pt, rd_slot);

  jps_ram #(
    .Width (HIST_W),
    .Depth (HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  jps_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_go_q),
    .sum_i     (acc_q),
    .divisor_i (n_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // Weighted average: 256*prev + w*(newest - prev) + 128, then floor by 256
  assign w_sat = (weight_q > WEIGHT_W'(ONE_Q8)) ? WEIGHT_W'(ONE_Q8) : weight_q;
  assign w_ext = $signed({1'b0, w_sat});
  assign diff  = (COORD_BITS+1)'(cur_q[c_q]) - (COORD_BITS+1)'(prev_q[c_q]);
  assign wma_t = (T_W'(prev_q[c_q]) <<< FRAC_Q8) + T_W'(prod_q) + T_W'(HALF_Q8);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_index_o = pidx_q;
  assign smooth_x_o  = res_q[0];
  assign smooth_y_o  = res_q[1];
  assign smooth_z_o  = res_q[2];
  assign out_state_o = ostate_q;

  // Control path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_NONE;
      window_q  <= WIN_W'(3);
      weight_q  <= WEIGHT_W'(205);
      k_q       <= '0;
      n_q       <= '0;
      rd_pend_q <= 1'b0;
      wma_q     <= 1'b0;
      div_go_q  <= 1'b0;
      c_q       <= '0;
      for (int p = 0; p < NUM_POINTS; p++) begin
        fill_q[p] <= '0;
        slot_q[p] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MODE:   mode_q   <= cfg_data_i[1:0];
          CFG_WINDOW: window_q <= cfg_data_i[WIN_W-1:0];
          CFG_WEIGHT: weight_q <= cfg_data_i;
          default: ;
        endcase
      end
      div_go_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (in_range) begin
            fill_q[pt] <= fill_new;
            slot_q[pt] <= (slot_q[pt] == SLOT_W'(MAX_WINDOW - 1)) ? '0 :
                          slot_q[pt] + SLOT_W'(1);
          end
          k_q       <= '0;
          rd_pend_q <= 1'b0;
          n_q       <= go_sma ? win : FILL_W'(2);
          wma_q     <= go_wma;
          state_q   <= (go_sma || go_wma) ? ST_READ : ST_OUT;
        end
        ST_READ: begin
          // issue one read a cycle; the read data arrives in the following cycle
          if (k_q < n_q) begin
            k_q <= k_q + FILL_W'(1);
          end
          rd_pend_q <= (k_q < n_q);
          if (last_rd) begin
            c_q <= '0;
            if (wma_q) begin
              state_q <= ST_MUL;
            end else begin
              div_go_q <= 1'b1;
              state_q  <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_MUL: begin
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          if (c_q == 2'(NUM_COORDS - 1)) begin
            state_q <= ST_OUT;
          end else begin
            c_q     <= c_q + 2'd1;
            state_q <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Data path
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pidx_q   <= point_index_i;
          tstate_q <= track_state_i;
          cur_q[0] <= pos_x_i;
          cur_q[1] <= pos_y_i;
          cur_q[2] <= pos_z_i;
        end
      end
      ST_WRITE: begin
        base_slot_q <= slot_q[pt];
        ostate_q    <= tstate_q;
        for (int c = 0; c < NUM_COORDS; c++) begin
          res_q[c] <= cur_q[c];
          acc_q[c] <= '0;
        end
      end
      ST_READ: begin
        if (rd_pend_q) begin
          for (int c = 0; c < NUM_COORDS; c++) begin
            acc_q[c]  <= acc_q[c] + sum_t'(coord_t'(ram_rdata[c*COORD_BITS +: COORD_BITS]));
            prev_q[c] <= ram_rdata[c*COORD_BITS +: COORD_BITS];
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ostate_q <= STATE_TRACKED;
          for (int c = 0; c < NUM_COORDS; c++) begin
            res_q[c] <= quot[c];
          end
        end
      end
      ST_MUL: begin
        prod_q <= PROD_W'(diff * w_ext);
      end
      ST_ADD: begin
        res_q[c_q] <= coord_t'(wma_t[FRAC_Q8 +: COORD_BITS]);
        ostate_q   <= STATE_TRACKED;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

endmodule

// ----- design/jps_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module jps_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/jps_div.sv -----
// Bit-serial signed divider, one quotient bit per cycle on three lanes.
// Quotient truncates toward zero. Depends on jps_pkg.
module jps_div import jps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sum_t              sum_i [NUM_COORDS],
  input  logic [FILL_W-1:0] divisor_i,
  output logic              done_o,
  output coord_t            quot_o [NUM_COORDS]
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [FILL_W-1:0] div_q;
  logic [SUM_W-1:0]  mag_q [NUM_COORDS];
  logic [FILL_W-1:0] rem_q [NUM_COORDS];
  logic              neg_q [NUM_COORDS];

  logic [FILL_W:0]   rem_sh [NUM_COORDS];
  logic              ge     [NUM_COORDS];
  logic [FILL_W-1:0] rem_d  [NUM_COORDS];
  logic [SUM_W-1:0]  mag_d  [NUM_COORDS];
  logic [SUM_W-1:0]  quot_w [NUM_COORDS];

  always_comb begin
    for (int l = 0; l < NUM_COORDS; l++) begin
      rem_sh[l] = {rem_q[l], mag_q[l][SUM_W-1]};
      ge[l]     = rem_sh[l] >= {1'b0, div_q};
      rem_d[l]  = ge[l] ? FILL_W'(rem_sh[l] - {1'b0, div_q}) : FILL_W'(rem_sh[l]);
      mag_d[l]  = {mag_q[l][SUM_W-2:0], ge[l]};
      quot_w[l] = neg_q[l] ? (~mag_q[l] + SUM_W'(1)) : mag_q[l];
      quot_o[l] = coord_t'(quot_w[l][COORD_BITS-1:0]);
    end
  end

  assign done_o = busy_q && (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(SUM_W);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      for (int l = 0; l < NUM_COORDS; l++) begin
        neg_q[l] <= sum_i[l][SUM_W-1];
        mag_q[l] <= sum_i[l][SUM_W-1] ? (~sum_i[l] + SUM_W'(1)) : sum_i[l];
        rem_q[l] <= '0;
      end
    end else if (busy_q && (cnt_q != '0)) begin
      for (int l = 0; l < NUM_COORDS; l++) begin
        mag_q[l] <= mag_d[l];
        rem_q[l] <= rem_d[l];
      end
    end
  end

endmodule
